@@ sv/keystroke_record_and_replay_defines.svh @@
// Assertion macros for the keystroke record and replay block.
`ifndef KEYSTROKE_RECORD_AND_REPLAY_DEFINES_SVH
`define KEYSTROKE_RECORD_AND_REPLAY_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define KRR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("keystroke_record_and_replay: property failed");

// Condition must never be true outside reset.
`define KRR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("keystroke_record_and_replay: forbidden condition seen");

`else

`define KRR_ASSERT(label, clk, rst_n, prop)
`define KRR_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ sv/krr_pkg.sv @@
// Shared types, constants and codes of the keystroke record and replay block.
`default_nettype none

package krr_pkg;

	// Field widths
	localparam int KEY_W    = 8;
	localparam int TIME_W   = 16;
	localparam int CNT_W    = 5;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Default record depth
	localparam int MAX_STROKES_DEF = 20;

	// Register reset values
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 16'd1000;
	localparam logic [KEY_W-1:0]  ERASE_RST   = 8'd42;
	localparam logic [KEY_W-1:0]  SHIFT_RST   = 8'd225;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_CODE   = 2'd2;

	// Operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REPLAY = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Result action codes
	localparam logic [1:0] ACT_STATUS = 2'd0;
	localparam logic [1:0] ACT_SET    = 2'd1;
	localparam logic [1:0] ACT_REPORT = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [KEY_W-1:0]  key_in;
		logic              any_shift_held;
		logic              left_shift_held;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key_out;
		logic             key_down;
		logic [CNT_W-1:0] stored_count;
		logic             last;
	} out_item_t;

	// Kind of result the datapath loads into the output register
	typedef enum logic [2:0] {
		EK_STATUS    = 3'd0,
		EK_SHIFT_SET = 3'd1,
		EK_PRESS     = 3'd2,
		EK_RELEASE   = 3'd3,
		EK_SHIFT_REL = 3'd4
	} emit_kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       idle;
		logic       capture;
		logic       clear;
		logic       add;
		logic       rd_issue;
		logic       idx_inc;
		logic       shift_take;
		logic       emit;
		emit_kind_t emit_kind;
		logic       last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       idx_end;
		logic       final_entry;
		logic       shift_held;
		logic       shift_diff;
		logic       out_free;
	} status_t;

endpackage

`default_nettype wire

@@ sv/krr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module krr_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 20,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/krr_ctrl.sv @@
// Sequencing state machine for add, clear and replay requests.
`default_nettype none

module krr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire krr_pkg::status_t st,
	output krr_pkg::cmd_t        cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ADD   = 8'b0000_0010,
		S_STAT  = 8'b0000_0100,
		S_RD    = 8'b0000_1000,
		S_CHK   = 8'b0001_0000,
		S_PRESS = 8'b0010_0000,
		S_REL   = 8'b0100_0000,
		S_SHREL = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_kind = krr_pkg::EK_STATUS;
		case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (st.op)
						krr_pkg::OP_ADD:    state_d = S_ADD;
						krr_pkg::OP_REPLAY: state_d = S_RD;
						krr_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
							state_d   = S_STAT;
						end
						default: state_d = S_STAT;
					endcase
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_STAT;
			end
			S_STAT: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = krr_pkg::EK_STATUS;
					cmd.last      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RD: begin
				// empty record: shift release if held, else a status result
				if (st.idx_end) begin
					state_d = st.shift_held ? S_SHREL : S_STAT;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_CHK: begin
				if (st.shift_diff) begin
					if (st.out_free) begin
						cmd.emit       = 1'b1;
						cmd.emit_kind  = krr_pkg::EK_SHIFT_SET;
						cmd.shift_take = 1'b1;
						state_d        = S_PRESS;
					end
				end else begin
					state_d = S_PRESS;
				end
			end
			S_PRESS: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = krr_pkg::EK_PRESS;
					state_d       = S_REL;
				end
			end
			S_REL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = krr_pkg::EK_RELEASE;
					cmd.last      = st.final_entry && !st.shift_held;
					cmd.idx_inc   = 1'b1;
					if (st.final_entry) begin
						state_d = st.shift_held ? S_SHREL : S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_SHREL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = krr_pkg::EK_SHIFT_REL;
					cmd.last      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/krr_dp.sv @@
// Datapath: registers, record memory, add arithmetic and output register.
`default_nettype none

module krr_dp #(
	parameter int MAX_STROKES = krr_pkg::MAX_STROKES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire krr_pkg::in_item_t                  in_data,
	output krr_pkg::out_item_t                      out_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	input  wire logic                               cfg_we,
	input  wire logic [krr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [krr_pkg::CFG_W-1:0]          cfg_data,
	input  wire krr_pkg::cmd_t                      cmd,
	output krr_pkg::status_t                        st
);

	localparam int IDX_W = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
	localparam int CNT_W = krr_pkg::CNT_W;
	localparam int KEY_W = krr_pkg::KEY_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STROKES);

	logic [krr_pkg::TIME_W-1:0] timeout_q;
	logic [KEY_W-1:0]           erase_q;
	logic [KEY_W-1:0]           shift_code_q;
	krr_pkg::in_item_t          req_q;
	logic [CNT_W-1:0]           count_q;
	logic [krr_pkg::TIME_W-1:0] last_time_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       shift_q;
	logic                       out_valid_q;
	krr_pkg::out_item_t         out_q;

	logic [krr_pkg::TIME_W-1:0] gap;
	logic [CNT_W-1:0]           eff_count;
	logic                       is_erase;
	logic                       is_full;
	logic                       ram_we;
	logic [KEY_W:0]             rd_entry;
	logic                       rd_shifted;
	logic [KEY_W-1:0]           rd_code;
	krr_pkg::out_item_t         res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= krr_pkg::TIMEOUT_RST;
			erase_q      <= krr_pkg::ERASE_RST;
			shift_code_q <= krr_pkg::SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				krr_pkg::REG_IDLE_TIMEOUT: timeout_q    <= cfg_data;
				krr_pkg::REG_ERASE_CODE:   erase_q      <= cfg_data[KEY_W-1:0];
				krr_pkg::REG_SHIFT_CODE:   shift_code_q <= cfg_data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	// Captured request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
	end

	// Add: wrap-safe gap, restart on timeout, then erase, append or, when full, keep
	assign gap       = req_q.now_ms - last_time_q;
	assign eff_count = (gap > timeout_q) ? '0 : count_q;
	assign is_erase  = (req_q.key_in == erase_q);
	assign is_full   = (eff_count >= MAX_CNT);
	assign ram_we    = cmd.add && !is_erase && !is_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_time_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.add) begin
			last_time_q <= req_q.now_ms;
			if (is_erase) begin
				count_q <= (eff_count != '0) ? eff_count - CNT_W'(1) : eff_count;
			end else if (is_full) begin
				count_q <= eff_count;
			end else begin
				count_q <= eff_count + CNT_W'(1);
			end
		end
	end

	// Replay walk: entry index and current shift state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			shift_q <= 1'b0;
		end else if (cmd.capture) begin
			idx_q   <= '0;
			shift_q <= in_data.left_shift_held;
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.shift_take) begin
				shift_q <= rd_shifted;
			end
		end
	end

	// Record memory: shifted flag over keycode
	krr_ram #(
		.WIDTH (KEY_W + 1),
		.DEPTH (MAX_STROKES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (eff_count[IDX_W-1:0]),
		.wdata ({req_q.any_shift_held, req_q.key_in}),
		.re    (cmd.rd_issue),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	assign rd_shifted = rd_entry[KEY_W];
	assign rd_code    = rd_entry[KEY_W-1:0];

	// Result formatting
	always_comb begin
		res              = '0;
		res.stored_count = count_q;
		res.last         = cmd.last;
		case (cmd.emit_kind)
			krr_pkg::EK_STATUS: begin
				res.action = krr_pkg::ACT_STATUS;
			end
			krr_pkg::EK_SHIFT_SET: begin
				res.action   = krr_pkg::ACT_SET;
				res.key_out  = shift_code_q;
				res.key_down = rd_shifted;
			end
			krr_pkg::EK_PRESS: begin
				res.action   = krr_pkg::ACT_REPORT;
				res.key_out  = rd_code;
				res.key_down = 1'b1;
			end
			krr_pkg::EK_RELEASE: begin
				res.action  = krr_pkg::ACT_REPORT;
				res.key_out = rd_code;
			end
			krr_pkg::EK_SHIFT_REL: begin
				res.action  = krr_pkg::ACT_REPORT;
				res.key_out = shift_code_q;
			end
			default: res.action = krr_pkg::ACT_STATUS;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller
	assign st.op          = in_data.op;
	assign st.idx_end     = (idx_q == count_q);
	assign st.final_entry = ((idx_q + CNT_W'(1)) == count_q);
	assign st.shift_held  = shift_q;
	assign st.shift_diff  = (rd_shifted != shift_q);
	assign st.out_free    = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

@@ sv/keystroke_record_and_replay.sv @@
// Top level of the keystroke record and replay block.
`default_nettype none

`include "keystroke_record_and_replay_defines.svh"

// Keeps up to MAX_STROKES keystrokes (keycode plus shifted flag) and handles
// one request at a time: add, replay or clear. An add passes through the add
// and status states before its single status result goes into the output
// register; a clear or an unused op code goes straight to the status state. A
// replay walks each recorded entry through the read, check, press and release
// states, the same whether or not the shift state changes, since a shift
// change goes out in the cycle that checks the entry. A final shift release
// adds its own state; an empty replay goes from the read state directly to
// the status or shift release state. A stalled waiting result holds the
// controller in its state. The sequence follows from the record memory's
// single registered read port and the one output register that each result
// passes through. While the final result of a request waits in the output
// register the next request can already be taken. There is no clearing pass:
// entries past the fill count are never read.
module keystroke_record_and_replay #(
	parameter int MAX_STROKES = krr_pkg::MAX_STROKES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire krr_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output krr_pkg::out_item_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [krr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [krr_pkg::CFG_W-1:0]     cfg_data
);

	krr_pkg::cmd_t    cmd;
	krr_pkg::status_t st;

	krr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd)
	);

	krr_dp #(
		.MAX_STROKES (MAX_STROKES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

	// Requests are taken only in the idle state
	assign in_stall = !cmd.idle;

	// A taken request leaves the controller busy on the next cycle
	`KRR_ASSERT(a_busy_after_take, clk, arst_n, cmd.capture |=> !cmd.idle)

	// A result is never loaded over one that is still waiting
	`KRR_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.emit && out_valid && out_stall)

	// The final result of a run returns the controller to idle
	`KRR_ASSERT(a_last_to_idle, clk, arst_n, (cmd.emit && cmd.last) |=> cmd.idle)

	// The reported fill never exceeds the record depth
	`KRR_ASSERT(a_count_bound, clk, arst_n,
		out_valid |-> (out_data.stored_count <= krr_pkg::CNT_W'(MAX_STROKES)))

endmodule

`default_nettype wire

@@ bench/keystroke_record_and_replay_tb.sv @@
// Self-checking testbench for the keystroke record and replay block.
`timescale 1ns / 1ps

module keystroke_record_and_replay_tb;
	import krr_pkg::*;

	localparam int MAX_STROKES  = MAX_STROKES_DEF;
	localparam int NUM_PROBES   = 22;
	localparam int RANDOM_ITEMS = 320;
	localparam int PHASE_ITEMS  = 40;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PRINT_CAP    = 30;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One row of the directed table: request plus an optional typed-in result
	typedef struct packed {
		in_item_t  req;
		logic      fixed;
		out_item_t result;
	} probe_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Predictor state and register copies
	logic [KEY_W-1:0]  log_code [MAX_STROKES];
	logic              log_shift [MAX_STROKES];
	logic [CNT_W-1:0]  stroke_total = '0;
	logic [TIME_W-1:0] last_stamp = '0;
	logic [TIME_W-1:0] cfg_timeout = TIMEOUT_RST;
	logic [KEY_W-1:0]  cfg_erase = ERASE_RST;
	logic [KEY_W-1:0]  cfg_shift = SHIFT_RST;

	out_item_t         pending_events [$];
	probe_row_t        probe_rows [NUM_PROBES];
	logic [TIME_W-1:0] stamp = '0;
	int                fail_count = 0;
	int                result_seen = 0;
	int                sent_count = 0;
	int                cycle_count = 0;
	int                in_gap_max = 9;
	int                out_gap_max = 9;

	keystroke_record_and_replay dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("ERROR @%0t result %0d: %s got %0d expected %0d",
				$realtime, result_seen, what, got_v, want_v);
	endtask

	function automatic void push_event(input logic [1:0] act, input logic [KEY_W-1:0] key,
		input logic down);
		out_item_t ev;
		ev.action       = act;
		ev.key_out      = key;
		ev.key_down     = down;
		ev.stored_count = stroke_total;
		ev.last         = 1'b0;
		pending_events.push_back(ev);
	endfunction

	// Applies one request to the record and queues the results it yields, a status result when there is no key event
	function automatic int predict_key_events(input in_item_t req);
		logic [TIME_W-1:0] gap;
		logic              held;
		int                produced;
		out_item_t         tail;
		produced = 0;
		case (req.op)
			OP_ADD: begin
				gap = req.now_ms - last_stamp;
				if (gap > cfg_timeout)
					stroke_total = '0;
				last_stamp = req.now_ms;
				if (req.key_in == cfg_erase) begin
					if (stroke_total != 0)
						stroke_total = stroke_total - 1'b1;
				end else if (stroke_total < MAX_STROKES) begin
					log_code[stroke_total]  = req.key_in;
					log_shift[stroke_total] = req.any_shift_held;
					stroke_total = stroke_total + 1'b1;
				end
			end
			OP_REPLAY: begin
				held = req.left_shift_held;
				for (int i = 0; i < stroke_total; i++) begin
					if (log_shift[i] != held) begin
						held = log_shift[i];
						push_event(ACT_SET, cfg_shift, held);
						produced++;
					end
					push_event(ACT_REPORT, log_code[i], 1'b1);
					push_event(ACT_REPORT, log_code[i], 1'b0);
					produced += 2;
				end
				if (held) begin
					push_event(ACT_REPORT, cfg_shift, 1'b0);
					produced++;
				end
			end
			OP_CLEAR: stroke_total = '0;
			default: ;
		endcase
		if (produced == 0) begin
			push_event(ACT_STATUS, '0, 1'b0);
			produced = 1;
		end
		tail = pending_events.pop_back();
		tail.last = 1'b1;
		pending_events.push_back(tail);
		return produced;
	endfunction

	function automatic probe_row_t probe(input logic [1:0] op, input logic [KEY_W-1:0] key,
		input logic any_sh, input logic left_sh, input logic [TIME_W-1:0] now,
		input logic fixed, input logic [1:0] act, input logic [KEY_W-1:0] kout,
		input logic down, input logic [CNT_W-1:0] cnt);
		probe_row_t row;
		row.req.op              = op;
		row.req.key_in          = key;
		row.req.any_shift_held  = any_sh;
		row.req.left_shift_held = left_sh;
		row.req.now_ms          = now;
		row.fixed               = fixed;
		row.result.action       = act;
		row.result.key_out      = kout;
		row.result.key_down     = down;
		row.result.stored_count = cnt;
		row.result.last         = 1'b1;
		return row;
	endfunction

	// Presents one request after a random gap and predicts it once taken
	task automatic send_request(input in_item_t req, input logic fixed, input out_item_t typed);
		int gap;
		int produced;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		produced = predict_key_events(req);
		if (fixed) begin
			repeat (produced) void'(pending_events.pop_back());
			pending_events.push_back(typed);
		end
		sent_count++;
	endtask

	// Lowers valid and waits until every predicted result has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IDLE_TIMEOUT: cfg_timeout = value;
			REG_ERASE_CODE:   cfg_erase   = value[KEY_W-1:0];
			REG_SHIFT_CODE:   cfg_shift   = value[KEY_W-1:0];
			default: ;
		endcase
	endtask

	// A run of adds within the timeout (now and then just past it), then a replay
	task automatic type_burst();
		int          n;
		int          pattern;
		logic [31:0] rnd;
		logic [16:0] step;
		in_item_t    req;
		n = $urandom_range(1, 24);
		pattern = $urandom_range(0, 2);
		for (int k = 0; k < n; k++) begin
			rnd = $urandom;
			req = rnd[$bits(in_item_t)-1:0];
			req.op = OP_ADD;
			if ($urandom_range(0, 7) == 0)
				req.key_in = cfg_erase;
			else if (req.key_in == cfg_erase)
				req.key_in = req.key_in + 1'b1;
			// alternating flags give the longest replays
			if (pattern == 1)
				req.any_shift_held = k[0];
			else if (pattern == 2)
				req.any_shift_held = 1'b1;
			step = $urandom_range(0, cfg_timeout);
			if ($urandom_range(0, 15) == 0)
				step = cfg_timeout + 17'd1;
			stamp = stamp + step[TIME_W-1:0];
			req.now_ms = stamp;
			send_request(req, 1'b0, '0);
		end
		rnd = $urandom;
		req = rnd[$bits(in_item_t)-1:0];
		req.op = OP_REPLAY;
		send_request(req, 1'b0, '0);
	endtask

	// Result checker
	task automatic check_result(input out_item_t got);
		out_item_t want;
		result_seen++;
		if (pending_events.size() == 0) begin
			report_mismatch("result with nothing pending, action", got.action, 0);
			return;
		end
		want = pending_events.pop_front();
		if (got.action != want.action)
			report_mismatch("action", got.action, want.action);
		if (got.key_out != want.key_out)
			report_mismatch("key_out", got.key_out, want.key_out);
		if (got.key_down != want.key_down)
			report_mismatch("key_down", got.key_down, want.key_down);
		if (got.stored_count != want.stored_count)
			report_mismatch("stored_count", got.stored_count, want.stored_count);
		if (got.last != want.last)
			report_mismatch("last", got.last, want.last);
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			check_result(out_data);

	// Receiver: random stall ahead of each result
	initial begin
		int n;
		forever begin
			n = $urandom_range(0, out_gap_max);
			@(negedge clk);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Reset, directed table, then random phases over several register settings
	initial begin : main_flow
		int                phase;
		int                phase_start;
		int                pick;
		logic [31:0]       rnd;
		logic [TIME_W-1:0] new_timeout;
		logic [KEY_W-1:0]  new_erase;
		logic [KEY_W-1:0]  new_shift;
		in_item_t          req;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		probe_rows = '{
			// empty record, both starting shift states
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b0, 16'd0, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b1, 16'd0, 1'b1, ACT_REPORT, 8'd225, 1'b0, 5'd0),
			probe(OP_UNUSED, 8'd255, 1'b1, 1'b1, 16'hFFFF, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_CLEAR, 8'd0, 1'b0, 1'b0, 16'd0, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			// erase on an empty record
			probe(OP_ADD, 8'd42, 1'b0, 1'b0, 16'd10, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_ADD, 8'd0, 1'b0, 1'b0, 16'd20, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd1),
			// gap equal to the timeout keeps the record
			probe(OP_ADD, 8'd255, 1'b1, 1'b0, 16'd1020, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd2),
			probe(OP_ADD, 8'd4, 1'b1, 1'b1, 16'd2020, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd3),
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b0, 16'd0, 1'b0, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b1, 16'd0, 1'b0, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_ADD, 8'd42, 1'b0, 1'b0, 16'd2030, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd2),
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b0, 16'd0, 1'b0, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			// one past the timeout restarts the record
			probe(OP_ADD, 8'd7, 1'b0, 1'b0, 16'd3031, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd1),
			probe(OP_ADD, 8'd9, 1'b1, 1'b0, 16'hFFFF, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd1),
			// time wraps past zero, gap is small
			probe(OP_ADD, 8'd10, 1'b1, 1'b0, 16'd5, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd2),
			probe(OP_ADD, 8'd42, 1'b0, 1'b0, 16'd6, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd1),
			probe(OP_ADD, 8'd42, 1'b0, 1'b0, 16'd7, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_ADD, 8'd42, 1'b1, 1'b1, 16'd8, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_ADD, 8'd225, 1'b0, 1'b0, 16'd9, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd1),
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b1, 16'd0, 1'b0, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_CLEAR, 8'd255, 1'b1, 1'b1, 16'hFFFF, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0),
			probe(OP_REPLAY, 8'd0, 1'b0, 1'b0, 16'd0, 1'b1, ACT_STATUS, 8'd0, 1'b0, 5'd0)
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NUM_PROBES; r++)
			send_request(probe_rows[r].req, probe_rows[r].fixed, probe_rows[r].result);
		stamp = 16'd9;

		phase = 0;
		while (sent_count < NUM_PROBES + RANDOM_ITEMS) begin
			settle();
			case (phase % 6)
				0: begin
					new_timeout = 16'd0;
					new_erase   = 8'd0;
					new_shift   = 8'd0;
				end
				1: begin
					new_timeout = 16'hFFFF;
					new_erase   = 8'hFF;
					new_shift   = 8'hFF;
				end
				2: begin
					new_timeout = TIMEOUT_RST;
					new_erase   = ERASE_RST;
					new_shift   = SHIFT_RST;
				end
				4: begin
					new_timeout = 16'd1;
					new_erase   = 8'hFF;
					new_shift   = 8'd0;
				end
				5: begin
					new_timeout = $urandom_range(0, 3000);
					new_erase   = $urandom_range(0, 255);
					new_shift   = $urandom_range(0, 255);
				end
				default: begin
					new_timeout = $urandom_range(0, 65535);
					new_erase   = $urandom_range(0, 255);
					new_shift   = $urandom_range(0, 255);
				end
			endcase
			write_reg(REG_IDLE_TIMEOUT, new_timeout);
			write_reg(REG_ERASE_CODE, {8'd0, new_erase});
			write_reg(REG_SHIFT_CODE, {8'd0, new_shift});

			// some phases run with no gaps on one side or the other
			in_gap_max  = (phase % 3 == 0) ? 0 : 9;
			out_gap_max = (phase % 4 == 1) ? 0 : 9;

			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_ITEMS &&
				sent_count < NUM_PROBES + RANDOM_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					type_burst();
				end else begin
					// noise over every field, or a plain clear
					rnd = $urandom;
					req = rnd[$bits(in_item_t)-1:0];
					if (pick == 9)
						req.op = OP_CLEAR;
					send_request(req, 1'b0, '0);
				end
			end
			phase++;
		end

		settle();
		in_gap_max  = 9;
		out_gap_max = 9;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
